// ===== rtl/core/accumulator_cpu_step_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the accumulator CPU step unit
// Each macro clocks on clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_CPU_STEP_UNIT_ASSERT_SVH
`define ACCUMULATOR_CPU_STEP_UNIT_ASSERT_SVH

// Same-cycle implication: cons holds whenever ante holds.
`define ACS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons holds in the cycle after ante.
`define ACS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/acs_pkg.sv =====
// ----------------------------------------------------------------------------
// acs_pkg
// Types, command codes and opcodes shared by the accumulator CPU step unit.
// ----------------------------------------------------------------------------
package acs_pkg;

	localparam int MEM_DEPTH_DEF = 256;

	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_EXEC  = 2'd2,
		CMD_START = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_OP,
		ST_OPND,
		ST_DATA,
		ST_RESP
	} state_t;

	// Opcodes, matched on the full byte
	localparam byte_t OP_HLT = 8'd240;
	localparam byte_t OP_STA = 8'd16;
	localparam byte_t OP_LDA = 8'd32;
	localparam byte_t OP_ADD = 8'd48;
	localparam byte_t OP_OR  = 8'd64;
	localparam byte_t OP_AND = 8'd80;
	localparam byte_t OP_NOT = 8'd96;
	localparam byte_t OP_JMP = 8'd128;
	localparam byte_t OP_JN  = 8'd144;
	localparam byte_t OP_JZ  = 8'd160;

endpackage

// ===== rtl/core/acs_req_if.sv =====
// ----------------------------------------------------------------------------
// acs_req_if
// Command channel: one beat carries a command, an address and a data byte.
// ----------------------------------------------------------------------------
interface acs_req_if;
	logic          valid;
	logic          ready;
	logic [1:0]    cmd;
	acs_pkg::byte_t address;
	acs_pkg::byte_t data;

	modport source (output valid, output cmd, output address, output data, input ready);
	modport sink   (input valid, input cmd, input address, input data, output ready);
endinterface

// ===== rtl/core/acs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// acs_rsp_if
// Result channel: one beat per command with read data and machine state.
// ----------------------------------------------------------------------------
interface acs_rsp_if;
	logic           valid;
	logic           ready;
	acs_pkg::byte_t read_data;
	acs_pkg::byte_t acc_value;
	acs_pkg::byte_t pc_value;
	logic           halted;

	modport source (output valid, output read_data, output acc_value, output pc_value,
		output halted, input ready);
	modport sink   (input valid, input read_data, input acc_value, input pc_value,
		input halted, output ready);
endinterface

// ===== rtl/core/acs_ram.sv =====
// ----------------------------------------------------------------------------
// acs_ram
// Single-port synchronous byte memory, registered read data.
// ----------------------------------------------------------------------------
module acs_ram #(
	parameter int DEPTH = acs_pkg::MEM_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  acs_pkg::byte_t           wdata,
	output acs_pkg::byte_t           rdata
);

	acs_pkg::byte_t mem [DEPTH];
	acs_pkg::byte_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/accumulator_cpu_step_unit.sv =====
// Path, accept to result valid: write, start or a halted execute via RESP; read via RD,
// RESP; STA, NOT, jumps, HLT or NOP via OP, OPND, RESP; LDA/ADD/OR/AND add DATA before RESP.
// A new command is taken only back in IDLE, after RESP loads the result; the single memory
// port serializes opcode, operand and data reads, one per cycle.
// Reset (arst_n low): accumulator, PC, halt flag, FSM and result valid clear at once;
// memory contents are undefined until written.
// ----------------------------------------------------------------------------
// accumulator_cpu_step_unit
// 8-bit accumulator machine stepped one command per beat: memory write, memory
// read, start, or execute one instruction. State memory is a synchronous RAM.
// ----------------------------------------------------------------------------
module accumulator_cpu_step_unit #(
	parameter int MEM_DEPTH = acs_pkg::MEM_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	acs_req_if.sink   req,
	acs_rsp_if.source rsp
);

	localparam int AW = $clog2(MEM_DEPTH);

	// Architectural registers
	acs_pkg::byte_t  acc_q;
	acs_pkg::byte_t  pc_q;
	logic            halt_q;

	// Control
	acs_pkg::state_t state_q, state_d;
	acs_pkg::byte_t  op_q;
	acs_pkg::byte_t  rd_q;

	// Result register
	logic            rsp_valid_q;
	acs_pkg::byte_t  rsp_read_data_q;
	acs_pkg::byte_t  rsp_acc_q;
	acs_pkg::byte_t  rsp_pc_q;
	logic            rsp_halted_q;

	// Memory port
	logic            mem_we;
	logic            mem_re;
	acs_pkg::byte_t  mem_addr;
	acs_pkg::byte_t  mem_wdata;
	acs_pkg::byte_t  mem_rdata;
	logic [AW-1:0]   mem_idx;
	logic [AW-1:0]   idx_lut [256];

	logic            req_ready;
	logic            req_fire;
	logic            rsp_load;
	acs_pkg::byte_t  pc_inc1;
	acs_pkg::byte_t  pc_inc2;

	assign req_fire = req.valid && req_ready;
	assign pc_inc1  = pc_q + 8'd1;
	assign pc_inc2  = pc_q + 8'd2;

	// Every byte address folds modulo the memory depth; a constant table does it.
	always_comb begin
		for (int i = 0; i < 256; i++) begin
			idx_lut[i] = AW'(i % MEM_DEPTH);
		end
	end

	assign mem_idx = idx_lut[mem_addr];

	acs_ram #(
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_idx),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// FSM state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory control. Reads are issued in the state before the
	// one that consumes mem_rdata.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = pc_q;
		mem_wdata = acc_q;
		req_ready = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			acs_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					case (acs_pkg::cmd_t'(req.cmd))
						acs_pkg::CMD_WRITE: begin
							mem_we    = 1'b1;
							mem_addr  = req.address;
							mem_wdata = req.data;
							state_d   = acs_pkg::ST_RESP;
						end
						acs_pkg::CMD_READ: begin
							mem_re   = 1'b1;
							mem_addr = req.address;
							state_d  = acs_pkg::ST_RD;
						end
						acs_pkg::CMD_EXEC: begin
							if (halt_q) begin
								// Halted: report state unchanged
								state_d = acs_pkg::ST_RESP;
							end else begin
								mem_re   = 1'b1;
								mem_addr = pc_q;
								state_d  = acs_pkg::ST_OP;
							end
						end
						acs_pkg::CMD_START: begin
							state_d = acs_pkg::ST_RESP;
						end
						default: begin
							state_d = acs_pkg::ST_RESP;
						end
					endcase
				end
			end
			acs_pkg::ST_RD: begin
				state_d = acs_pkg::ST_RESP;
			end
			acs_pkg::ST_OP: begin
				// Opcode on mem_rdata; fetch the operand byte
				mem_re   = 1'b1;
				mem_addr = pc_inc1;
				state_d  = acs_pkg::ST_OPND;
			end
			acs_pkg::ST_OPND: begin
				// Operand on mem_rdata
				case (op_q)
					acs_pkg::OP_STA: begin
						mem_we    = 1'b1;
						mem_addr  = mem_rdata;
						mem_wdata = acc_q;
						state_d   = acs_pkg::ST_RESP;
					end
					acs_pkg::OP_LDA, acs_pkg::OP_ADD, acs_pkg::OP_OR, acs_pkg::OP_AND: begin
						mem_re   = 1'b1;
						mem_addr = mem_rdata;
						state_d  = acs_pkg::ST_DATA;
					end
					default: begin
						state_d = acs_pkg::ST_RESP;
					end
				endcase
			end
			acs_pkg::ST_DATA: begin
				state_d = acs_pkg::ST_RESP;
			end
			acs_pkg::ST_RESP: begin
				// Hold here while the previous result still waits
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = acs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = acs_pkg::ST_IDLE;
			end
		endcase
	end

	// Accumulator, PC and halt flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= 8'd0;
			pc_q   <= 8'd0;
			halt_q <= 1'b0;
		end else begin
			case (state_q)
				acs_pkg::ST_IDLE: begin
					if (req_fire && (acs_pkg::cmd_t'(req.cmd) == acs_pkg::CMD_START)) begin
						acc_q  <= req.data;
						pc_q   <= req.address;
						halt_q <= 1'b0;
					end
				end
				acs_pkg::ST_OPND: begin
					case (op_q)
						acs_pkg::OP_HLT: begin
							halt_q <= 1'b1;
						end
						acs_pkg::OP_STA: begin
							pc_q <= pc_inc2;
						end
						acs_pkg::OP_LDA, acs_pkg::OP_ADD, acs_pkg::OP_OR, acs_pkg::OP_AND: begin
							// Finish in the data state
							pc_q <= pc_q;
						end
						acs_pkg::OP_NOT: begin
							acc_q <= ~acc_q;
							pc_q  <= pc_inc1;
						end
						acs_pkg::OP_JMP: begin
							pc_q <= mem_rdata;
						end
						acs_pkg::OP_JN: begin
							pc_q <= acc_q[7] ? mem_rdata : pc_inc2;
						end
						acs_pkg::OP_JZ: begin
							pc_q <= (acc_q == 8'd0) ? mem_rdata : pc_inc2;
						end
						default: begin
							// Unknown byte: step over it
							pc_q <= pc_inc1;
						end
					endcase
				end
				acs_pkg::ST_DATA: begin
					case (op_q)
						acs_pkg::OP_LDA: acc_q <= mem_rdata;
						acs_pkg::OP_ADD: acc_q <= acc_q + mem_rdata;
						acs_pkg::OP_OR:  acc_q <= acc_q | mem_rdata;
						acs_pkg::OP_AND: acc_q <= acc_q & mem_rdata;
						default:         acc_q <= acc_q;
					endcase
					pc_q <= pc_inc2;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	// Opcode latch and read data capture
	always_ff @(posedge clk) begin
		if (state_q == acs_pkg::ST_OP) begin
			op_q <= mem_rdata;
		end
		if (req_fire) begin
			rd_q <= 8'd0;
		end else if (state_q == acs_pkg::ST_RD) begin
			rd_q <= mem_rdata;
		end
	end

	// Result register: load a beat, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_read_data_q <= rd_q;
			rsp_acc_q       <= acc_q;
			rsp_pc_q        <= pc_q;
			rsp_halted_q    <= halt_q;
		end
	end

	assign req.ready     = req_ready;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rsp_read_data_q;
	assign rsp.acc_value = rsp_acc_q;
	assign rsp.pc_value  = rsp_pc_q;
	assign rsp.halted    = rsp_halted_q;

	`include "accumulator_cpu_step_unit_assert.svh"

	`ACS_ASSERT_NEXT(a_halted_exec_idle, req_fire && (req.cmd == acs_pkg::CMD_EXEC) && halt_q, (state_q == acs_pkg::ST_RESP) && $stable(pc_q) && $stable(acc_q), "execute while halted changed state")
	`ACS_ASSERT_NOW(a_mem_write_src, mem_we, ((state_q == acs_pkg::ST_IDLE) && req.valid && (req.cmd == acs_pkg::CMD_WRITE)) || ((state_q == acs_pkg::ST_OPND) && (op_q == acs_pkg::OP_STA)), "memory write outside write command or STA")
	`ACS_ASSERT_NOW(a_rsp_from_resp, $rose(rsp.valid), $past(state_q) == acs_pkg::ST_RESP, "result beat raised outside response state")
	`ACS_ASSERT_NEXT(a_start_loads, req_fire && (req.cmd == acs_pkg::CMD_START), !halt_q && (pc_q == $past(req.address)) && (acc_q == $past(req.data)), "start did not load PC, accumulator and halt")

endmodule

// ===== tb/sv/tb_accumulator_cpu_step_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accumulator_cpu_step_unit
// Self-checking bench for the accumulator CPU step unit. A short hand-written
// program touches every opcode, the wrap cases and the halted state. Random
// programs then follow, each loaded, started and stepped, mixed with stray
// commands. A scoreboard class mirrors memory, AC, PC and halt and checks
// every result beat in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_accumulator_cpu_step_unit;
	import acs_pkg::*;

	localparam int TOTAL_ITEMS  = 1450;
	localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either channel
	localparam int DRAIN_CYCLES = 12;    // longest command runs OP, OPND, DATA, RESP
	localparam int HOLD_OFF     = 400;   // one long receiver stall
	localparam int HOLD_AFTER   = 300;   // results seen before the long stall

	// Machine state reported after one command
	typedef struct packed {
		byte_t rd;
		byte_t acc;
		byte_t pc;
		logic  halt;
	} cpu_report_t;

	// Mirror of the machine: predicts each report and checks the DUT against it
	class cpu_scoreboard;
		byte_t       mem [256];
		bit          written [256];
		byte_t       acc;
		byte_t       pc;
		bit          halt;
		cpu_report_t due_reports [$];
		int          n_bad;
		int          n_checked;
		int          n_noted;
		int          cmd_count [4];
		int          n_halted_exec;
		int          n_taken;

		function new();
			acc = '0;
			pc = '0;
			halt = 1'b0;
			n_bad = 0;
			n_checked = 0;
			n_noted = 0;
			n_halted_exec = 0;
			n_taken = 0;
			foreach (written[i])
				written[i] = 1'b0;
			foreach (cmd_count[i])
				cmd_count[i] = 0;
		endfunction

		function void run_instruction();
			byte_t op;
			byte_t arg;
			byte_t next1;
			byte_t next2;
			next1 = pc + 8'd1;
			next2 = pc + 8'd2;
			op = mem[pc];
			arg = mem[next1];
			if (halt) begin
				n_halted_exec++;
				return;
			end
			case (op)
				OP_HLT: halt = 1'b1;
				OP_STA: begin
					mem[arg] = acc;
					written[arg] = 1'b1;
					pc = next2;
				end
				OP_LDA: begin
					acc = mem[arg];
					pc = next2;
				end
				OP_ADD: begin
					acc = acc + mem[arg];
					pc = next2;
				end
				OP_OR: begin
					acc = acc | mem[arg];
					pc = next2;
				end
				OP_AND: begin
					acc = acc & mem[arg];
					pc = next2;
				end
				OP_NOT: begin
					acc = ~acc;
					pc = next1;
				end
				OP_JMP: pc = arg;
				OP_JN: begin
					if (acc[7])
						n_taken++;
					pc = acc[7] ? arg : next2;
				end
				OP_JZ: begin
					if (acc == 8'd0)
						n_taken++;
					pc = (acc == 8'd0) ? arg : next2;
				end
				default: pc = next1;
			endcase
		endfunction

		function void accept_command(cmd_t c, byte_t a, byte_t d);
			cpu_report_t r;
			r.rd = '0;
			case (c)
				CMD_WRITE: begin
					mem[a] = d;
					written[a] = 1'b1;
				end
				CMD_READ:  r.rd = mem[a];
				CMD_EXEC:  run_instruction();
				default: begin
					acc = d;
					pc = a;
					halt = 1'b0;
				end
			endcase
			r.acc = acc;
			r.pc = pc;
			r.halt = halt;
			due_reports.push_back(r);
			cmd_count[c]++;
			n_noted++;
		endfunction

		function void check_result(byte_t got_rd, byte_t got_acc, byte_t got_pc,
				logic got_halt);
			cpu_report_t want;
			n_checked++;
			if (due_reports.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("[%0t] result with no command outstanding: rd=%02h acc=%02h pc=%02h h=%b",
						$time, got_rd, got_acc, got_pc, got_halt);
				return;
			end
			want = due_reports.pop_front();
			if (want.rd !== got_rd || want.acc !== got_acc || want.pc !== got_pc
					|| want.halt !== got_halt) begin
				n_bad++;
				if (n_bad <= 10)
					$display("[%0t] result %0d: exp rd=%02h acc=%02h pc=%02h h=%b, got rd=%02h acc=%02h pc=%02h h=%b",
						$time, n_checked, want.rd, want.acc, want.pc, want.halt,
						got_rd, got_acc, got_pc, got_halt);
			end
		endfunction

		function int pending();
			return due_reports.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	acs_req_if req_ch ();
	acs_rsp_if rsp_ch ();

	accumulator_cpu_step_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	cpu_scoreboard sb;
	bit            send_calm;
	bit            hold_done;

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Command side
	// ------------------------------------------------------------------------

	// Pick the idle gap after a beat: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (send_calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// Offer one beat, hold it until taken, then note it in the mirror
	task automatic issue_command(input cmd_t c, input byte_t a, input byte_t d);
		int gap;
		req_ch.valid   <= 1'b1;
		req_ch.cmd     <= c;
		req_ch.address <= a;
		req_ch.data    <= d;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.accept_command(c, a, d);
		// Re-pick whether the sender runs without gaps for a while
		if (sb.n_noted % 64 == 0)
			send_calm = ($urandom_range(0, 3) == 0);
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Mostly real opcodes, otherwise any byte (treated as NOP unless it matches an opcode)
	function automatic byte_t pick_code();
		case ($urandom_range(0, 12))
			0:       return OP_HLT;
			1:       return OP_STA;
			2:       return OP_LDA;
			3:       return OP_ADD;
			4:       return OP_OR;
			5:       return OP_AND;
			6:       return OP_NOT;
			7:       return OP_JMP;
			8:       return OP_JN;
			9:       return OP_JZ;
			default: return byte_t'($urandom);
		endcase
	endfunction

	// Starting accumulator: bias toward zero, sign bit and the carry edges
	function automatic byte_t pick_acc();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'h80;
			2:       return 8'hFF;
			3:       return 8'h7F;
			default: return byte_t'($urandom);
		endcase
	endfunction

	// Write a byte before anything reads it; never read an unwritten location
	task automatic ensure_byte(input byte_t a, input bit as_code);
		if (!sb.written[a])
			issue_command(CMD_WRITE, a, as_code ? pick_code() : byte_t'($urandom));
	endtask

	// Read back some memory byte
	task automatic peek_memory();
		byte_t a;
		a = byte_t'($urandom);
		ensure_byte(a, 1'b0);
		issue_command(CMD_READ, a, byte_t'($urandom));
	endtask

	// Execute one instruction, first filling whatever bytes it will read
	task automatic step_machine();
		byte_t at;
		byte_t nxt;
		byte_t op;
		at = sb.pc;
		nxt = at + 8'd1;
		ensure_byte(at, 1'b1);
		ensure_byte(nxt, 1'b0);
		op = sb.mem[at];
		if (op == OP_LDA || op == OP_ADD || op == OP_OR || op == OP_AND)
			ensure_byte(sb.mem[nxt], 1'b0);
		issue_command(CMD_EXEC, byte_t'($urandom), byte_t'($urandom));
	endtask

	// Load a short program at a random base, start it and step it
	task automatic load_and_run_program();
		byte_t base;
		byte_t at;
		int    n_ins;
		int    n_steps;
		base = byte_t'($urandom);
		at = base;
		n_ins = $urandom_range(1, 6);
		repeat (n_ins) begin
			issue_command(CMD_WRITE, at, pick_code());
			at = at + 8'd1;
			// Keep half the operands near the program so jumps loop back into it
			issue_command(CMD_WRITE, at, $urandom_range(0, 1) ?
				byte_t'(base + $urandom_range(0, 12)) : byte_t'($urandom));
			at = at + 8'd1;
		end
		issue_command(CMD_START, base, pick_acc());
		n_steps = $urandom_range(1, 14);
		repeat (n_steps) begin
			if ($urandom_range(0, 15) == 0)
				peek_memory();
			step_machine();
		end
	endtask

	// One command out of program order
	task automatic stray_command();
		cmd_t c;
		c = cmd_t'($urandom_range(0, 3));
		case (c)
			CMD_WRITE: issue_command(CMD_WRITE, byte_t'($urandom), byte_t'($urandom));
			CMD_READ:  peek_memory();
			CMD_EXEC:  step_machine();
			default:   issue_command(CMD_START, byte_t'($urandom), pick_acc());
		endcase
	endtask

	// Hand-written program: every opcode, PC and ADD wrap, untaken branch,
	// self-modifying store, halt and an execute while halted
	task automatic run_directed();
		issue_command(CMD_WRITE, 8'd255, 8'hFF);
		issue_command(CMD_WRITE, 8'd254, OP_ADD);
		issue_command(CMD_WRITE, 8'd0,   OP_JN);
		issue_command(CMD_WRITE, 8'd1,   8'h0F);
		issue_command(CMD_WRITE, 8'd2,   OP_JZ);
		issue_command(CMD_WRITE, 8'd3,   8'd6);
		issue_command(CMD_WRITE, 8'd5,   OP_HLT);
		issue_command(CMD_WRITE, 8'd6,   OP_NOT);
		issue_command(CMD_WRITE, 8'd7,   OP_STA);
		issue_command(CMD_WRITE, 8'd8,   8'd9);
		issue_command(CMD_WRITE, 8'd10,  OP_AND);
		issue_command(CMD_WRITE, 8'd11,  8'd1);
		issue_command(CMD_WRITE, 8'd12,  OP_OR);
		issue_command(CMD_WRITE, 8'd13,  8'd0);
		issue_command(CMD_WRITE, 8'd14,  OP_LDA);
		issue_command(CMD_WRITE, 8'd15,  8'd7);
		issue_command(CMD_WRITE, 8'd16,  OP_JMP);
		issue_command(CMD_WRITE, 8'd17,  8'd5);
		// ADD at 254 carries out and wraps PC to 0; JN at 0 falls through,
		// JZ at 2 jumps; STA plants a NOP at 9; JMP lands on HLT at 5
		issue_command(CMD_START, 8'd254, 8'h01);
		repeat (12)
			issue_command(CMD_EXEC, byte_t'($urandom), byte_t'($urandom));
		issue_command(CMD_READ, 8'd9, 8'h00);
	endtask

	// ------------------------------------------------------------------------
	// Result side: accept beats, stall at random, and hold off once for long
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int stall_left;
		int cyc;
		bit calm;
		stall_left = 0;
		cyc = 0;
		calm = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready)
				sb.check_result(rsp_ch.read_data, rsp_ch.acc_value, rsp_ch.pc_value,
					rsp_ch.halted);
			cyc++;
			if (cyc % 200 == 0)
				calm = ($urandom_range(0, 3) == 0);
			// Hold off long enough that the unit fills and stalls the command side
			if (!hold_done && sb.n_checked >= HOLD_AFTER) begin
				hold_done = 1'b1;
				stall_left = HOLD_OFF;
			end
			if (stall_left == 0 && !calm && $urandom_range(0, 99) < 20)
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
					: $urandom_range(1, 3);
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if neither channel moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no beat for %0d cycles, %0d reports outstanding",
			QUIET_LIMIT, sb.pending());
		$display("tb_accumulator_cpu_step_unit: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main_seq
		sb = new();
		send_calm = 1'b0;
		hold_done = 1'b0;
		arst_n <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.cmd     <= CMD_WRITE;
		req_ch.address <= '0;
		req_ch.data    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		while (sb.n_noted < TOTAL_ITEMS) begin
			if ($urandom_range(0, 9) < 7)
				load_and_run_program();
			else
				stray_command();
		end
		req_ch.valid <= 1'b0;

		// Drain: wait for every report, then watch a little longer for extras
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d commands: %0d writes, %0d reads, %0d starts, %0d executes",
			sb.n_noted, sb.cmd_count[CMD_WRITE], sb.cmd_count[CMD_READ],
			sb.cmd_count[CMD_START], sb.cmd_count[CMD_EXEC]);
		$display("%0d executes while halted, %0d branches taken, %0d results checked, %0d bad",
			sb.n_halted_exec, sb.n_taken, sb.n_checked, sb.n_bad);
		if (sb.n_bad == 0 && sb.pending() == 0)
			$display("tb_accumulator_cpu_step_unit: PASS");
		else
			$display("tb_accumulator_cpu_step_unit: FAIL");
		$finish;
	end

endmodule
